>>> hw/rtl/sjis_to_8bit_charset_stream_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Shift-JIS to 8-bit charset stream block
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SJIS_TO_8BIT_CHARSET_STREAM_TOP_DEFINES_SVH
`define SJIS_TO_8BIT_CHARSET_STREAM_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SJIS8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define SJIS8_ASSERT_NEVER(lbl, expr, msg) \
  `SJIS8_ASSERT(lbl, !(expr), msg)
`else
`define SJIS8_ASSERT(lbl, prop, msg)
`define SJIS8_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

>>> hw/rtl/sjis8_pkg.sv
// ----------------------------------------------------------------------------
// sjis8_pkg
// Types, code tables and lookup functions for the Shift-JIS converter.
// ----------------------------------------------------------------------------
package sjis8_pkg;

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int CharRomDepth  = 256;
  localparam int MarkRomDepth  = 51;
  localparam int MarkSemiFirst = 40;
  localparam int MarkVuIdx     = 50;

  localparam logic [7:0]  LeadLow       = 8'h80;
  localparam logic [7:0]  LeadHigh      = 8'h9f;
  localparam logic [7:0]  CtrlHigh      = 8'h1f;
  localparam logic [7:0]  ChTab         = 8'h09;
  localparam logic [7:0]  ChLf          = 8'h0a;
  localparam logic [7:0]  ChCr          = 8'h0d;
  localparam logic [7:0]  ChNul         = 8'h00;
  localparam logic [7:0]  GraphicMax    = 8'h1f;
  localparam logic [7:0]  GraphicPrefix = 8'h14;
  localparam logic [7:0]  GraphicOffset = 8'h30;
  localparam logic [7:0]  VoicedByte    = 8'hde;
  localparam logic [7:0]  SemiByte      = 8'hdf;
  localparam logic [15:0] VuCode        = 16'h8345;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_PAIR = 2'd1,
    KIND_TERM = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MARK_NONE   = 2'd0,
    MARK_VOICED = 2'd1,
    MARK_SEMI   = 2'd2
  } mark_e;

  // queue entry: for KIND_BYTE the byte sits in code[7:0]
  typedef struct packed {
    kind_e       kind;
    logic [15:0] code;
    mark_e       mark;
  } entry_t;

  typedef struct packed {
    logic [15:0] code;
    mark_e       mark;
  } pair_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] idx;
  } find_t;

  localparam logic [15:0] MarkRom [MarkRomDepth] = '{
    16'h82aa, 16'h82ac, 16'h82ae, 16'h82b0, 16'h82b2,
    16'h82b4, 16'h82b6, 16'h82b8, 16'h82ba, 16'h82bc,
    16'h82be, 16'h82c0, 16'h82c3, 16'h82c5, 16'h82c7,
    16'h82ce, 16'h82d1, 16'h82d4, 16'h82d7, 16'h82da,
    16'h834b, 16'h834d, 16'h834f, 16'h8351, 16'h8353,
    16'h8355, 16'h8357, 16'h8359, 16'h835b, 16'h835d,
    16'h835f, 16'h8361, 16'h8364, 16'h8366, 16'h8368,
    16'h836f, 16'h8372, 16'h8375, 16'h8378, 16'h837b,
    16'h82cf, 16'h82d2, 16'h82d5, 16'h82d8, 16'h82db,
    16'h8370, 16'h8373, 16'h8376, 16'h8379, 16'h837c,
    16'h8394
  };

  localparam logic [15:0] CharRom [CharRomDepth] = '{
    16'h0000, 16'h8c8e, 16'h89ce, 16'h9085, 16'h96d8, 16'h8be0, 16'h9379, 16'h93fa,
    16'h944e, 16'h897e, 16'h8e9e, 16'h95aa, 16'h9562, 16'h9553, 16'h90e7, 16'h969c,
    16'h83ce, 16'h84b3, 16'h84b1, 16'h84b2, 16'h84b0, 16'h84b4, 16'h84ab, 16'h84aa,
    16'h84ac, 16'h84ad, 16'h84af, 16'h84ae, 16'h817e, 16'h91e5, 16'h9286, 16'h8fac,
    16'h8140, 16'h8149, 16'h8168, 16'h8194, 16'h8190, 16'h8193, 16'h8195, 16'h8166,
    16'h8169, 16'h816a, 16'h8196, 16'h817b, 16'h8143, 16'h817c, 16'h8144, 16'h815e,
    16'h824f, 16'h8250, 16'h8251, 16'h8252, 16'h8253, 16'h8254, 16'h8255, 16'h8256,
    16'h8257, 16'h8258, 16'h8146, 16'h8147, 16'h8183, 16'h8181, 16'h8184, 16'h8148,
    16'h8197, 16'h8260, 16'h8261, 16'h8262, 16'h8263, 16'h8264, 16'h8265, 16'h8266,
    16'h8267, 16'h8268, 16'h8269, 16'h826a, 16'h826b, 16'h826c, 16'h826d, 16'h826e,
    16'h826f, 16'h8270, 16'h8271, 16'h8272, 16'h8273, 16'h8274, 16'h8275, 16'h8276,
    16'h8277, 16'h8278, 16'h8279, 16'h816b, 16'h818f, 16'h816c, 16'h814f, 16'h8151,
    16'h0000, 16'h8281, 16'h8282, 16'h8283, 16'h8284, 16'h8285, 16'h8286, 16'h8287,
    16'h8288, 16'h8289, 16'h828a, 16'h828b, 16'h828c, 16'h828d, 16'h828e, 16'h828f,
    16'h8290, 16'h8291, 16'h8292, 16'h8293, 16'h8294, 16'h8295, 16'h8296, 16'h8297,
    16'h8298, 16'h8299, 16'h829a, 16'h816f, 16'h8162, 16'h8170, 16'h8160, 16'h8140,
    16'h81a3, 16'h81a5, 16'h819a, 16'h819f, 16'h819b, 16'h819c, 16'h82f0, 16'h829f,
    16'h82a1, 16'h82a3, 16'h82a5, 16'h82a7, 16'h82e1, 16'h82e3, 16'h82e5, 16'h82c1,
    16'h0000, 16'h82a0, 16'h82a2, 16'h82a4, 16'h82a6, 16'h82a8, 16'h82a9, 16'h82ab,
    16'h82ad, 16'h82af, 16'h82b1, 16'h82b3, 16'h82b5, 16'h82b7, 16'h82b9, 16'h82bb,
    16'h0000, 16'h8142, 16'h8175, 16'h8176, 16'h8141, 16'h8145, 16'h8392, 16'h8340,
    16'h8342, 16'h8344, 16'h8346, 16'h8348, 16'h8383, 16'h8385, 16'h8387, 16'h8362,
    16'h815b, 16'h8341, 16'h8343, 16'h8345, 16'h8347, 16'h8349, 16'h834a, 16'h834c,
    16'h834e, 16'h8350, 16'h8352, 16'h8354, 16'h8356, 16'h8358, 16'h835a, 16'h835c,
    16'h835e, 16'h8360, 16'h8363, 16'h8365, 16'h8367, 16'h8369, 16'h836a, 16'h836b,
    16'h836c, 16'h836d, 16'h836e, 16'h8371, 16'h8374, 16'h8377, 16'h837a, 16'h837d,
    16'h837e, 16'h8380, 16'h8381, 16'h8382, 16'h8384, 16'h8386, 16'h8388, 16'h8389,
    16'h838a, 16'h838b, 16'h838c, 16'h838d, 16'h838f, 16'h8393, 16'h814a, 16'h814b,
    16'h82bd, 16'h82bf, 16'h82c2, 16'h82c4, 16'h82c6, 16'h82c8, 16'h82c9, 16'h82ca,
    16'h82cb, 16'h82cc, 16'h82cd, 16'h82d0, 16'h82d3, 16'h82d6, 16'h82d9, 16'h82dc,
    16'h82dd, 16'h82de, 16'h82df, 16'h82e0, 16'h82e2, 16'h82e4, 16'h82e6, 16'h82e7,
    16'h82e8, 16'h82e9, 16'h82ea, 16'h82eb, 16'h82ed, 16'h82f1, 16'h0000, 16'h0000
  };

  // voiced / semi-voiced mark split; first match wins
  function automatic pair_t mark_adjust(input logic [15:0] code);
    pair_t r;
    logic  hit;
    r.code = code;
    r.mark = MARK_NONE;
    hit    = 1'b0;
    for (int i = 0; i < MarkRomDepth; i++) begin
      if (!hit && MarkRom[i] == code) begin
        hit = 1'b1;
        if (i == MarkVuIdx) begin
          r.mark = MARK_VOICED;
          r.code = VuCode;
        end else if (i < MarkSemiFirst) begin
          r.mark = MARK_VOICED;
          r.code = code - 16'd1;
        end else begin
          r.mark = MARK_SEMI;
          r.code = code - 16'd2;
        end
      end
    end
    return r;
  endfunction

  // reverse lookup, lowest matching index
  function automatic find_t char_find(input logic [15:0] code);
    find_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int i = CharRomDepth - 1; i >= 0; i--) begin
      if (CharRom[i] == code) begin
        r.hit = 1'b1;
        r.idx = 8'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/sjis_to_8bit_charset_stream_top.sv
// ----------------------------------------------------------------------------
// sjis_to_8bit_charset_stream_top
// Shift-JIS byte stream to 8-bit home-computer character code stream.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata (low bit up)                     tlast        tuser
// s_axis    in   [7:0] in_byte                          -            -
// m_axis    out  [7:0] out_byte, [23:8] string_length   last_of_run  end_of_string
//
// Input reaches the output through the queue write, then the output register.
// One input transaction per cycle while each byte yields at most one result
// and m_axis does not stall; a character that yields two bytes keeps the
// back from popping the queue until its second byte is loaded.
// rst_ni is asynchronous; it clears the held lead byte, CR flag, queue,
// pending byte and length count. A stall on m_axis fills the two-entry
// queue before s_axis_tready_o drops.
//
`include "sjis_to_8bit_charset_stream_top_defines.svh"

module sjis_to_8bit_charset_stream_top #(
  parameter longint unsigned MAX_STRING_LENGTH = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] out_byte, [23:8] string_length
  output logic        m_axis_tlast_o,   // last_of_run
  output logic        m_axis_tuser_o    // end_of_string
);
  import sjis8_pkg::*;

  // length cap never exceeds the 16-bit field
  localparam logic [15:0] LenCap =
    (MAX_STRING_LENGTH < 64'd65535) ? 16'(MAX_STRING_LENGTH) : 16'hffff;

  logic   push, pop, q_full, q_empty;
  entry_t entry, head;

  // front: pairing, control filter, mark split
  sjis8_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .push_o          (push),
    .entry_o         (entry),
    .q_full_i        (q_full)
  );

  // decouples front from output backpressure
  sjis8_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // back: character ROM search, byte emission, length count
  sjis8_back #(
    .LEN_CAP (LenCap)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  `SJIS8_ASSERT_NEVER(a_q_no_overflow, push && q_full, "queue push while full")
  `SJIS8_ASSERT_NEVER(a_q_no_underflow, pop && q_empty, "queue pop while empty")
  `SJIS8_ASSERT(a_eos_is_last, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o, "terminator not last")
  `SJIS8_ASSERT(a_len_only_eos, m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[23:8] == 16'd0, "length on non-terminator")

endmodule

>>> hw/rtl/sjis8_front.sv
// ----------------------------------------------------------------------------
// sjis8_front
// Accepts source bytes, pairs lead bytes, filters controls, splits marks.
// ----------------------------------------------------------------------------
module sjis8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,
  output logic              push_o,
  output sjis8_pkg::entry_t entry_o,
  input  logic              q_full_i
);
  import sjis8_pkg::*;

  logic [7:0] held_lead_q, held_lead_d;
  logic       awaiting_q, awaiting_d;
  logic       after_cr_q, after_cr_d;
  logic       accept;
  pair_t      pair;
  logic [7:0] b;

  assign s_axis_tready_o = !q_full_i;
  assign accept          = s_axis_tvalid_i && !q_full_i;
  assign b               = s_axis_tdata_i;
  assign pair            = mark_adjust({held_lead_q, b});

  always_comb begin
    held_lead_d = held_lead_q;
    awaiting_d  = awaiting_q;
    after_cr_d  = after_cr_q;
    push_o      = 1'b0;
    entry_o     = '{kind: KIND_BYTE, code: {8'h00, b}, mark: MARK_NONE};
    if (accept) begin
      after_cr_d = 1'b0;
      if (b == ChNul) begin
        push_o        = 1'b1;
        entry_o.kind  = KIND_TERM;
        held_lead_d   = '0;
        awaiting_d    = 1'b0;
      end else if (awaiting_q) begin
        push_o        = 1'b1;
        entry_o.kind  = KIND_PAIR;
        entry_o.code  = pair.code;
        entry_o.mark  = pair.mark;
        held_lead_d   = '0;
        awaiting_d    = 1'b0;
      end else if (b >= LeadLow && b <= LeadHigh) begin
        held_lead_d = b;
        awaiting_d  = 1'b1;
      end else if (b <= CtrlHigh) begin
        if (b == ChTab) begin
          push_o = 1'b1;
        end else if (b == ChLf) begin
          push_o       = !after_cr_q;
          entry_o.code = {8'h00, ChCr};
        end else if (b == ChCr) begin
          push_o       = 1'b1;
          entry_o.code = {8'h00, ChCr};
          after_cr_d   = 1'b1;
        end
      end else begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_lead_q <= '0;
      awaiting_q  <= 1'b0;
      after_cr_q  <= 1'b0;
    end else begin
      held_lead_q <= held_lead_d;
      awaiting_q  <= awaiting_d;
      after_cr_q  <= after_cr_d;
    end
  end

endmodule

>>> hw/rtl/sjis8_queue.sv
// ----------------------------------------------------------------------------
// sjis8_queue
// Small register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module sjis8_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sjis8_pkg::entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output sjis8_pkg::entry_t head_o
);
  import sjis8_pkg::*;

  entry_t            slot_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> hw/rtl/sjis8_back.sv
// ----------------------------------------------------------------------------
// sjis8_back
// Character lookup, byte emission, length count and output register.
// ----------------------------------------------------------------------------
module sjis8_back #(
  parameter logic [15:0] LEN_CAP = 16'hffff
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  sjis8_pkg::entry_t head_i,
  output logic              pop_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [23:0]       m_axis_tdata_o,
  output logic              m_axis_tlast_o,
  output logic              m_axis_tuser_o
);
  import sjis8_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [15:0] out_len_q, out_len_d;
  logic        out_last_q, out_last_d;
  logic        out_eos_q, out_eos_d;
  logic        pend_valid_q, pend_valid_d;
  logic [7:0]  pend_byte_q, pend_byte_d;
  logic [15:0] count_q, count_d;
  logic [15:0] count_inc;
  logic        load_en;
  find_t       found;

  assign found     = char_find(head_i.code);
  assign load_en   = !out_valid_q || m_axis_tready_i;
  assign count_inc = (count_q < LEN_CAP) ? count_q + 16'd1 : count_q;

  always_comb begin
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_byte_d   = out_byte_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;
    out_eos_d    = out_eos_q;
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;
    count_d      = count_q;
    pop_o        = 1'b0;
    if (load_en) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_byte_d   = pend_byte_q;
        out_len_d    = '0;
        out_last_d   = 1'b1;
        out_eos_d    = 1'b0;
        pend_valid_d = 1'b0;
        count_d      = count_inc;
      end else if (!q_empty_i) begin
        pop_o      = 1'b1;
        out_len_d  = '0;
        out_last_d = 1'b1;
        out_eos_d  = 1'b0;
        case (head_i.kind)
          KIND_BYTE: begin
            out_valid_d = 1'b1;
            out_byte_d  = head_i.code[7:0];
            count_d     = count_inc;
          end
          KIND_TERM: begin
            out_valid_d = 1'b1;
            out_byte_d  = ChNul;
            out_eos_d   = 1'b1;
            out_len_d   = (count_q < LEN_CAP) ? count_q + 16'd1 : LEN_CAP;
            count_d     = '0;
          end
          KIND_PAIR: begin
            if (found.hit) begin
              out_valid_d = 1'b1;
              count_d     = count_inc;
              if (found.idx <= GraphicMax) begin
                out_byte_d   = GraphicPrefix;
                out_last_d   = 1'b0;
                pend_valid_d = 1'b1;
                pend_byte_d  = found.idx + GraphicOffset;
              end else begin
                out_byte_d = found.idx;
                if (head_i.mark != MARK_NONE) begin
                  out_last_d   = 1'b0;
                  pend_valid_d = 1'b1;
                  pend_byte_d  = (head_i.mark == MARK_VOICED) ? VoicedByte : SemiByte;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      count_q      <= '0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_len_q   <= out_len_d;
    out_last_q  <= out_last_d;
    out_eos_q   <= out_eos_d;
    pend_byte_q <= pend_byte_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_len_q, out_byte_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_eos_q;

endmodule
